FILE: rtl/mp2x2_pkg.sv
// shared types and constants for the 2x2 stride-2 max pooling block
`timescale 1ns / 1ps

package mp2x2_pkg;

   localparam int MAX_WIDTH    = 128;
   localparam int MAX_CHANNELS = 64;
   localparam int LINE_DEPTH   = (MAX_WIDTH / 2) * MAX_CHANNELS;

   localparam int COL_W   = $clog2(MAX_WIDTH);        // input column / row counter
   localparam int CH_W    = $clog2(MAX_CHANNELS);     // channel counter
   localparam int SLOT_W  = $clog2(LINE_DEPTH);       // line store address
   localparam int PROD_W  = COL_W - 1 + 7;            // pooled column times channel count

   localparam logic [7:0] ROW_WIDTH_RST     = 8'd32;
   localparam logic [7:0] FRAME_HEIGHT_RST  = 8'd32;
   localparam logic [6:0] CHANNEL_COUNT_RST = 7'd8;

   typedef logic signed [7:0] pixel_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [CH_W-1:0]   ch_type;
   typedef logic [SLOT_W-1:0] slot_type;

   typedef enum logic [1:0] {
      REG_ROW_WIDTH     = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_CHANNEL_COUNT = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/mp2x2_ifs.sv
// valid/ready channel interfaces for pixels, pooled results and register writes
`timescale 1ns / 1ps

interface mp2x2_req_if;
   import mp2x2_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel_value;
   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mp2x2_rsp_if;
   import mp2x2_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pooled_value;
   logic      frame_last;
   modport source (output valid, output pooled_value, output frame_last, input ready);
   modport sink   (input valid, input pooled_value, input frame_last, output ready);
endinterface

interface mp2x2_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/max_pool_2x2_stride2.sv
// top level: streaming 2x2 stride-2 max pooling over a line store of partial maxima
`timescale 1ns / 1ps

// channel   direction  payload                       transfer when
// req_ch    in         pixel_value (s8)              valid && ready
// rsp_ch    out        pooled_value (s8), frame_last valid && ready
// csr_ch    in         index (2b), data (8b)         valid && ready (ready always high)
//
// one pixel per cycle unless stage 1 holds a result; a window's last pixel meets
// its registered memory read in stage 1, then the result enters the output register
// reset (synchronous) loads width 32, height 32, channels 8 and zeroes the position
// counters; the line memory is not cleared, a window's top-left value writes it first
// a stalled result holds stage 1 only when that stage also carries a result, so
// pixels keep flowing while a finished result waits to be taken

module max_pool_2x2_stride2 (
   input  logic clock,
   input  logic reset,
   mp2x2_req_if.sink   req_ch,
   mp2x2_rsp_if.source rsp_ch,
   mp2x2_csr_if.sink   csr_ch
);
   import mp2x2_pkg::*;

   // configuration registers
   logic [7:0] row_width_ff, row_width_in;
   logic [7:0] frame_height_ff, frame_height_in;
   logic [6:0] channel_count_ff, channel_count_in;

   // position counters
   col_type col_ff, col_in;
   col_type row_ff, row_in;
   ch_type  ch_ff, ch_in;

   // stage 1: pixel waiting for its line entry
   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_pixel_ff;
   slot_type  s1_slot_ff;
   logic      s1_use_ff;    // inside the used area, touches the line store
   logic      s1_first_ff;  // top-left of its window
   logic      s1_emit_ff;   // bottom-right of its window
   logic      s1_last_ff;
   pixel_type rd_ff;

   // last write to the line store, covers a read issued on the same edge
   logic      byp_valid_ff, byp_valid_in;
   slot_type  byp_slot_ff;
   pixel_type byp_data_ff;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_value_ff;
   logic      rsp_last_ff;

   pixel_type line_mem_ff [LINE_DEPTH];

   logic       csr_write;
   logic       accept;
   logic [7:0] w_eff, h_eff, w_used, h_used;
   logic [6:0] c_eff;
   logic       in_window, top_row, left_col;
   logic       is_last;
   logic [PROD_W-1:0] slot_prod, slot_sum;
   slot_type   slot_in;
   pixel_type  prev_max, new_max;
   logic       out_free, s1_adv;

   // ---------------------------------------------------------------- configuration
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      row_width_in     = row_width_ff;
      frame_height_in  = frame_height_ff;
      channel_count_in = channel_count_ff;
      if (csr_write) begin
         case (csr_ch.index)
            REG_ROW_WIDTH:     row_width_in     = csr_ch.data;
            REG_FRAME_HEIGHT:  frame_height_in  = csr_ch.data;
            REG_CHANNEL_COUNT: channel_count_in = csr_ch.data[6:0];
            default: ;
         endcase
      end
   end

   // effective geometry, saturated to the supported range
   always_comb begin
      if (row_width_ff < 8'd2)                    w_eff = 8'd2;
      else if (row_width_ff > 8'(MAX_WIDTH))      w_eff = 8'(MAX_WIDTH);
      else                                        w_eff = row_width_ff;
      if (frame_height_ff < 8'd2)                 h_eff = 8'd2;
      else if (frame_height_ff > 8'(MAX_WIDTH))   h_eff = 8'(MAX_WIDTH);
      else                                        h_eff = frame_height_ff;
      if (channel_count_ff == 7'd0)               c_eff = 7'd1;
      else if (channel_count_ff > 7'(MAX_CHANNELS)) c_eff = 7'(MAX_CHANNELS);
      else                                        c_eff = channel_count_ff;
   end

   // an odd last column or row falls outside every window
   assign w_used = {w_eff[7:1], 1'b0};
   assign h_used = {h_eff[7:1], 1'b0};

   // ---------------------------------------------------------------- front end
   assign accept = req_ch.valid && req_ch.ready;

   assign in_window = ({1'b0, col_ff} < w_used) && ({1'b0, row_ff} < h_used);
   assign top_row   = !row_ff[0];
   assign left_col  = !col_ff[0];
   assign is_last   = ({1'b0, row_ff} == h_used - 8'd1) &&
                      ({1'b0, col_ff} == w_used - 8'd1) &&
                      ({1'b0, ch_ff} == c_eff - 7'd1);

   // one entry per pooled column and channel
   assign slot_prod = PROD_W'(col_ff[COL_W-1:1]) * PROD_W'(c_eff);
   assign slot_sum  = slot_prod + PROD_W'(ch_ff);
   assign slot_in   = slot_sum[SLOT_W-1:0];

   // raster walk: channel, then column, then row; any register write restarts the frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ch_in  = ch_ff;
      if (csr_write && (csr_ch.index == REG_ROW_WIDTH || csr_ch.index == REG_FRAME_HEIGHT ||
                        csr_ch.index == REG_CHANNEL_COUNT)) begin
         col_in = '0;
         row_in = '0;
         ch_in  = '0;
      end else if (accept) begin
         if ({1'b0, ch_ff} == c_eff - 7'd1) begin
            ch_in = '0;
            if ({1'b0, col_ff} == w_eff - 8'd1) begin
               col_in = '0;
               if ({1'b0, row_ff} == h_eff - 8'd1) row_in = '0;
               else                                 row_in = row_ff + col_type'(1);
            end else begin
               col_in = col_ff + col_type'(1);
            end
         end else begin
            ch_in = ch_ff + ch_type'(1);
         end
      end
   end

   // ---------------------------------------------------------------- stage 1
   // the entry read on the accept edge misses a write made on that same edge
   assign prev_max = (byp_valid_ff && byp_slot_ff == s1_slot_ff) ? byp_data_ff : rd_ff;
   assign new_max  = (s1_first_ff || s1_pixel_ff > prev_max) ? s1_pixel_ff : prev_max;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv   = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_adv;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   assign byp_valid_in = byp_valid_ff || (s1_adv && s1_use_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_emit_ff)  rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)     rsp_valid_in = 1'b0;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= ROW_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         channel_count_ff <= CHANNEL_COUNT_RST;
         col_ff           <= '0;
         row_ff           <= '0;
         ch_ff            <= '0;
         s1_valid_ff      <= 1'b0;
         byp_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         row_width_ff     <= row_width_in;
         frame_height_ff  <= frame_height_in;
         channel_count_ff <= channel_count_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         ch_ff            <= ch_in;
         s1_valid_ff      <= s1_valid_in;
         byp_valid_ff     <= byp_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_ch.pixel_value;
         s1_slot_ff  <= slot_in;
         s1_use_ff   <= in_window;
         s1_first_ff <= top_row && left_col;
         s1_emit_ff  <= in_window && !top_row && !left_col;
         s1_last_ff  <= is_last;
      end
   end

   // bypass copy of the latest line write
   always_ff @(posedge clock) begin
      if (s1_adv && s1_use_ff) begin
         byp_slot_ff <= s1_slot_ff;
         byp_data_ff <= new_max;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_value_ff <= new_max;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   // line memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (s1_adv && s1_use_ff) line_mem_ff[s1_slot_ff] <= new_max;
   end

   always_ff @(posedge clock) begin
      if (accept) rd_ff <= line_mem_ff[slot_in];
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pooled_value = rsp_value_ff;
   assign rsp_ch.frame_last   = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, ch_ff} < c_eff) && ({1'b0, col_ff} < w_eff) && ({1'b0, row_ff} < h_eff))
      else $error("position counter outside the configured frame");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_ch.index == REG_ROW_WIDTH || csr_ch.index == REG_FRAME_HEIGHT ||
                     csr_ch.index == REG_CHANNEL_COUNT))
      |=> (col_ff == '0 && row_ff == '0 && ch_ff == '0))
      else $error("register write did not restart the frame");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_slot_ff) && $stable(s1_pixel_ff)))
      else $error("stalled stage 1 item was lost or changed");

   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emit_ff) |-> out_free)
      else $error("result written over an untaken result");

endmodule
